/* hdl/lpd_pkg.sv */
// Shared types and constants for the length-prefix deframer.
// No dependencies.
`default_nettype none

package lpd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
  } lpd_result_t;

endpackage

`default_nettype wire

/* hdl/lpd_front.sv */
// Front end: takes stream bytes, builds the length header, classifies payload bytes.
// Depends on lpd_pkg.
`default_nettype none

module lpd_front
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  in_byte,
  output lpd_result_t      result,
  output logic             emit
);

  // header size held to 1..4 bytes
  localparam int unsigned HDR_N    = (HEADER_BYTES < 1) ? 1 :
                                     ((HEADER_BYTES > 4) ? 4 : HEADER_BYTES);
  localparam int unsigned LEN_W    = 8 * HDR_N;
  localparam logic [1:0]  LAST_POS = 2'(HDR_N - 1);

  logic             in_payload, in_payload_next;
  logic [1:0]       header_position, header_position_next;
  logic [LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [LEN_W-1:0] acc;
  logic [LEN_W-1:0] dec;

  always_comb begin
    for (int i = 0; i < HDR_N; i++) begin
      if (header_position == 2'(i)) begin
        acc[8*i +: 8] = in_byte;
      end else if (header_position == 2'd0) begin
        acc[8*i +: 8] = 8'd0;
      end else begin
        acc[8*i +: 8] = bytes_remaining[8*i +: 8];
      end
    end
  end

  assign dec = bytes_remaining - LEN_W'(1);

  always_comb begin
    in_payload_next      = in_payload;
    header_position_next = header_position;
    bytes_remaining_next = bytes_remaining;
    emit                 = 1'b0;
    result.payload_byte  = in_byte;
    result.last_of_frame = 1'b0;
    result.empty_frame   = 1'b0;
    if (!in_payload) begin
      bytes_remaining_next = acc;
      if (header_position >= LAST_POS) begin
        header_position_next = 2'd0;
        if (acc == '0) begin
          emit                 = 1'b1;
          result.payload_byte  = 8'd0;
          result.last_of_frame = 1'b1;
          result.empty_frame   = 1'b1;
        end else begin
          in_payload_next = 1'b1;
        end
      end else begin
        header_position_next = header_position + 2'd1;
      end
    end else begin
      emit                 = 1'b1;
      bytes_remaining_next = dec;
      result.last_of_frame = (dec == '0);
      if (dec == '0) begin
        in_payload_next      = 1'b0;
        header_position_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      header_position <= 2'd0;
      bytes_remaining <= '0;
    end else if (take) begin
      in_payload      <= in_payload_next;
      header_position <= header_position_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/lpd_queue.sv */
// Result queue and output stage between the front end and the output channel.
// Depends on lpd_pkg.
`default_nettype none

module lpd_queue
  import lpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire lpd_result_t push_data,
  output logic       has_space,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output lpd_result_t pop_data
);

  lpd_result_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] rd_ptr, wr_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign has_space = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/length_prefix_deframer.sv */
// Length-prefix deframer: HEADER_BYTES little-endian length, then payload bytes.
// A result is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while the queue has space; header bytes give
// no result; the 2-entry queue keeps input flowing while one result waits.
// Reset (synchronous): parser returns to header position zero, queue empties.
// Depends on lpd_pkg, lpd_front, lpd_queue.
`default_nettype none

module length_prefix_deframer
  import lpd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] in_byte,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      payload_byte,
  output logic            last_of_frame,
  output logic            empty_frame
);

  logic        take;
  logic        emit;
  lpd_result_t front_result;
  lpd_result_t queue_out;

  assign take = byte_valid && byte_ready;

  lpd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .in_byte(in_byte),
    .result (front_result),
    .emit   (emit)
  );

  lpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take && emit),
    .push_data(front_result),
    .has_space(byte_ready),
    .pop_valid(result_valid),
    .pop_ready(result_ready),
    .pop_data (queue_out)
  );

  assign payload_byte  = queue_out.payload_byte;
  assign last_of_frame = queue_out.last_of_frame;
  assign empty_frame   = queue_out.empty_frame;

endmodule

`default_nettype wire
